FILE: hdl/fsr_pkg.sv
// ============================================================================
// fsr_pkg: shared constants and a helper for the Fresnel specular block
// Field widths, pipeline depth and the Q1.15 saturation helper.
// ============================================================================
package fsr_pkg;

    // One channel of a packed color or vector
    localparam int CH_W = 16;
    localparam int RGB_W = 3 * CH_W;

    // Q1.15 unity, one bit wider than a channel
    localparam logic [CH_W:0] ONE_Q15 = 17'd32768;

    // Register stages from input word to output register
    localparam int NUM_STAGES = 10;

    // Input and output stream word widths
    localparam int S_TDATA_W = 272;
    localparam int M_TDATA_W = RGB_W;

    // Clamp an unsigned Q1.15 factor to 1.0
    function automatic logic [CH_W:0] sat_one(input logic [CH_W-1:0] v);
        logic [CH_W:0] r;
        r = {1'b0, v};
        if (r > ONE_Q15) begin
            r = ONE_Q15;
        end
        return r;
    endfunction

endpackage

FILE: hdl/fsr_datapath.sv
// ============================================================================
// fsr_datapath: ten-stage arithmetic pipeline for the specular term
// Dot product, (1 - N.V)^5, roughness-aware Schlick term, SSR blend and the
// final color product. Each stage loads only when its enable is high.
// ============================================================================
module fsr_datapath (
    input  logic                                aclk,
    input  logic [fsr_pkg::NUM_STAGES-1:0]      stage_en,
    input  logic [fsr_pkg::RGB_W-1:0]           f0_rgb,
    input  logic [fsr_pkg::CH_W-1:0]            roughness,
    input  logic [fsr_pkg::RGB_W-1:0]           normal_xyz,
    input  logic [fsr_pkg::RGB_W-1:0]           view_xyz,
    input  logic [fsr_pkg::RGB_W-1:0]           env_spec_rgb,
    input  logic [fsr_pkg::RGB_W-1:0]           ssr_spec_rgb,
    input  logic                                ssr_valid,
    input  logic [fsr_pkg::CH_W-1:0]            ssr_weight,
    output logic [fsr_pkg::RGB_W-1:0]           specular_rgb
);
    import fsr_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] prod;
        logic [CH_W:0]    om;
        logic [CH_W:0]    w;
        logic [RGB_W-1:0] f0;
        logic [RGB_W-1:0] env;
        logic [RGB_W-1:0] ssr;
        logic             sv;
    } st1_t;

    typedef struct packed {
        logic [CH_W:0]    x;
        logic [CH_W:0]    t;
        logic [CH_W:0]    om;
        logic [RGB_W-1:0] f0;
        logic [RGB_W-1:0] env;
        logic [RGB_W-1:0] ssr;
        logic             sv;
    } st2_t;

    typedef struct packed {
        logic [CH_W:0]    p;
        logic [CH_W:0]    x;
        logic [CH_W:0]    om;
        logic [RGB_W-1:0] f0;
        logic [RGB_W-1:0] env;
        logic [2:0][32:0] ea;
        logic [2:0][32:0] sb;
        logic             sv;
    } st3_t;

    typedef struct packed {
        logic [CH_W:0]    p;
        logic [CH_W:0]    x;
        logic [CH_W:0]    om;
        logic [RGB_W-1:0] f0;
        logic [RGB_W-1:0] col;
    } st4_t;

    typedef struct packed {
        logic [CH_W:0]    p;
        logic [RGB_W-1:0] f0;
        logic [RGB_W-1:0] col;
        logic [2:0][CH_W:0] diff;
    } st6_t;

    typedef struct packed {
        logic [RGB_W-1:0] f0;
        logic [RGB_W-1:0] col;
        logic [2:0][33:0] fp;
    } st7_t;

    typedef struct packed {
        logic [RGB_W-1:0] fr;
        logic [RGB_W-1:0] col;
    } st8_t;

    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    st4_t st5_reg, st5_next;
    st6_t st6_reg, st6_next;
    st7_t st7_reg, st7_next;
    st8_t st8_reg, st8_next;
    logic [2:0][31:0] st9_reg, st9_next;
    logic [RGB_W-1:0] st10_reg, st10_next;

    // Stage 1: per-axis products of N and V, saturate roughness and weight
    always_comb begin
        logic signed [CH_W-1:0] n_c;
        logic signed [CH_W-1:0] v_c;
        logic signed [31:0]     pr;
        for (int k = 0; k < 3; k++) begin
            n_c = normal_xyz[k*CH_W +: CH_W];
            v_c = view_xyz[k*CH_W +: CH_W];
            pr  = 32'(n_c) * 32'(v_c);
            st1_next.prod[k] = pr;
        end
        st1_next.om  = ONE_Q15 - sat_one(roughness);
        st1_next.w   = sat_one(ssr_weight);
        st1_next.f0  = f0_rgb;
        st1_next.env = env_spec_rgb;
        st1_next.ssr = ssr_spec_rgb;
        st1_next.sv  = ssr_valid;
    end

    // Stage 2: sum the dot product, clamp to [0,1], x = 1 - c; blend factor t
    always_comb begin
        logic signed [33:0] d;
        logic [18:0]        c_raw;
        logic [CH_W:0]      c;
        logic [33:0]        tw;
        d = {{2{st1_reg.prod[0][31]}}, st1_reg.prod[0]}
          + {{2{st1_reg.prod[1][31]}}, st1_reg.prod[1]}
          + {{2{st1_reg.prod[2][31]}}, st1_reg.prod[2]};
        c_raw = d[33:15];
        if (d[33] || (d == '0)) begin
            c = '0;
        end else if (c_raw > {2'b00, ONE_Q15}) begin
            c = ONE_Q15;
        end else begin
            c = c_raw[CH_W:0];
        end
        tw = 34'(st1_reg.w) * 34'(st1_reg.om);
        st2_next.x   = ONE_Q15 - c;
        st2_next.t   = tw[31:15];
        st2_next.om  = st1_reg.om;
        st2_next.f0  = st1_reg.f0;
        st2_next.env = st1_reg.env;
        st2_next.ssr = st1_reg.ssr;
        st2_next.sv  = st1_reg.sv;
    end

    // Stage 3: p = x^2, and the two blend products per channel
    always_comb begin
        logic [33:0]   sq;
        logic [CH_W:0] inv_t;
        sq    = 34'(st2_reg.x) * 34'(st2_reg.x);
        inv_t = ONE_Q15 - st2_reg.t;
        for (int k = 0; k < 3; k++) begin
            st3_next.ea[k] = 33'(st2_reg.env[k*CH_W +: CH_W]) * 33'(inv_t);
            st3_next.sb[k] = 33'(st2_reg.ssr[k*CH_W +: CH_W]) * 33'(st2_reg.t);
        end
        st3_next.p   = sq[31:15];
        st3_next.x   = st2_reg.x;
        st3_next.om  = st2_reg.om;
        st3_next.f0  = st2_reg.f0;
        st3_next.env = st2_reg.env;
        st3_next.sv  = st2_reg.sv;
    end

    // Stage 4: p = x^3; pick env or the SSR mix
    always_comb begin
        logic [33:0] pm;
        logic [33:0] mix;
        pm = 34'(st3_reg.p) * 34'(st3_reg.x);
        for (int k = 0; k < 3; k++) begin
            mix = {1'b0, st3_reg.ea[k]} + {1'b0, st3_reg.sb[k]};
            st4_next.col[k*CH_W +: CH_W] = st3_reg.sv ? mix[30:15]
                                                      : st3_reg.env[k*CH_W +: CH_W];
        end
        st4_next.p  = pm[31:15];
        st4_next.x  = st3_reg.x;
        st4_next.om = st3_reg.om;
        st4_next.f0 = st3_reg.f0;
    end

    // Stage 5: p = x^4
    always_comb begin
        logic [33:0] pm;
        pm = 34'(st4_reg.p) * 34'(st4_reg.x);
        st5_next   = st4_reg;
        st5_next.p = pm[31:15];
    end

    // Stage 6: p = x^5; per channel max(om, f0) - f0
    always_comb begin
        logic [33:0]   pm;
        logic [CH_W:0] f;
        pm = 34'(st5_reg.p) * 34'(st5_reg.x);
        for (int k = 0; k < 3; k++) begin
            f = {1'b0, st5_reg.f0[k*CH_W +: CH_W]};
            st6_next.diff[k] = (st5_reg.om > f) ? (st5_reg.om - f) : '0;
        end
        st6_next.p   = pm[31:15];
        st6_next.f0  = st5_reg.f0;
        st6_next.col = st5_reg.col;
    end

    // Stage 7: Schlick product (max - f0) * p
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            st7_next.fp[k] = 34'(st6_reg.diff[k]) * 34'(st6_reg.p);
        end
        st7_next.f0  = st6_reg.f0;
        st7_next.col = st6_reg.col;
    end

    // Stage 8: F = f0 + product, fits a channel
    always_comb begin
        logic [CH_W:0] s;
        for (int k = 0; k < 3; k++) begin
            s = {1'b0, st7_reg.f0[k*CH_W +: CH_W]} + st7_reg.fp[k][31:15];
            st8_next.fr[k*CH_W +: CH_W] = s[CH_W-1:0];
        end
        st8_next.col = st7_reg.col;
    end

    // Stage 9: F * color
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            st9_next[k] = 32'(st8_reg.fr[k*CH_W +: CH_W])
                        * 32'(st8_reg.col[k*CH_W +: CH_W]);
        end
    end

    // Stage 10: scale back and saturate each channel
    always_comb begin
        logic [CH_W:0] o;
        for (int k = 0; k < 3; k++) begin
            o = st9_reg[k][31:15];
            st10_next[k*CH_W +: CH_W] = o[CH_W] ? {CH_W{1'b1}} : o[CH_W-1:0];
        end
    end

    // Stage registers, payload only
    always_ff @(posedge aclk) begin
        if (stage_en[0]) st1_reg  <= st1_next;
        if (stage_en[1]) st2_reg  <= st2_next;
        if (stage_en[2]) st3_reg  <= st3_next;
        if (stage_en[3]) st4_reg  <= st4_next;
        if (stage_en[4]) st5_reg  <= st5_next;
        if (stage_en[5]) st6_reg  <= st6_next;
        if (stage_en[6]) st7_reg  <= st7_next;
        if (stage_en[7]) st8_reg  <= st8_next;
        if (stage_en[8]) st9_reg  <= st9_next;
        if (stage_en[9]) st10_reg <= st10_next;
    end

    assign specular_rgb = st10_reg;

endmodule

FILE: hdl/fresnel_specular_reflection_top.sv
// ============================================================================
// fresnel_specular_reflection_top: per-pixel roughness-aware Fresnel specular
// Streams one shaded pixel per clock, unless m_tready stalls it, in ten stages.
// ============================================================================
// Usage:
//   Slave channel s_*: one pixel word per handshake. s_tdata carries F0,
//   roughness, N, V, env color, SSR color and SSR weight; s_tuser carries
//   the SSR valid flag. Master channel m_*: one specular color word per
//   input word, in order.
//   Each input word is registered through the ten register stages of the
//   datapath (four of them form the fifth-power chain); m_tvalid is the
//   valid bit of the last. Throughput: one word per cycle while m_tready
//   stays high.
//   Every stage has its own valid bit and loads when it is empty or when
//   the stage after it moves, so bubbles collapse while the output stalls.
//   When the receiver holds m_tready low, m_tdata stays put and upstream
//   stages keep filling until the pipeline is full; then s_tready drops.
//   Reset (aresetn low, synchronous) clears all valid bits; no word is in
//   flight afterwards. There is no state carried between pixels.
// ============================================================================
module fresnel_specular_reflection_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata, lowest bit up: f0_rgb[47:0], roughness[63:48],
    // normal_xyz[111:64], view_xyz[159:112], env_spec_rgb[207:160],
    // ssr_spec_rgb[255:208], ssr_weight[271:256]
    input  logic [fsr_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: ssr_valid
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata, lowest bit up: specular_rgb[47:0]
    output logic [fsr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import fsr_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    // Per-stage load enable: a stage moves when empty or when its successor moves
    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    // Valid bits travel with the data
    always_comb begin
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    fsr_datapath u_datapath (
        .aclk         (aclk),
        .stage_en     (stage_en),
        .f0_rgb       (s_tdata[47:0]),
        .roughness    (s_tdata[63:48]),
        .normal_xyz   (s_tdata[111:64]),
        .view_xyz     (s_tdata[159:112]),
        .env_spec_rgb (s_tdata[207:160]),
        .ssr_spec_rgb (s_tdata[255:208]),
        .ssr_valid    (s_tuser),
        .ssr_weight   (s_tdata[271:256]),
        .specular_rgb (m_tdata)
    );

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

endmodule

FILE: hdl/fsr_checker.sv
// ============================================================================
// fsr_checker: port-level checks for the Fresnel specular block
// Watches the stream handshakes of the top level; bound in below.
// ============================================================================
module fsr_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fsr_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready
);
    import fsr_pkg::*;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word present right after reset");

    // An empty or draining output never blocks the input side
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled while the output side can move");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output word changed or vanished");

    // Input side accepts nothing more only when the output is stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |-> (m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

endmodule

bind fresnel_specular_reflection_top fsr_checker u_fsr_checker (.*);

FILE: tb/sv/fresnel_specular_reflection_top_tb.sv
// ============================================================================
// fresnel_specular_reflection_top_tb: self-checking bench for the specular block
// Drives pixel words through the slave stream and checks every specular word
// on the master stream against an in-bench model of the fixed-point Fresnel
// math. A short directed table runs first, then 1130 random pixels.
// Both sides idle and stall at random.
// ============================================================================
module fresnel_specular_reflection_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fsr_pkg::S_TDATA_W;
    import fsr_pkg::M_TDATA_W;
    import fsr_pkg::NUM_STAGES;

    localparam longint unsigned Q15_ONE = 32768;
    localparam longint unsigned CH_MAX  = 65535;
    localparam int RAND_PIXELS = 1130;
    localparam int CHUNK       = 50;

    // Unit axes, x in the low channel
    localparam logic [47:0] AXIS_X = 48'h0000_0000_7FFF;
    localparam logic [47:0] AXIS_Y = 48'h0000_7FFF_0000;
    localparam logic [47:0] AXIS_Z = 48'h7FFF_0000_0000;
    localparam logic [47:0] NEG_Z  = 48'h8000_0000_0000;

    // One pixel; packed so that {s_tuser, s_tdata} is the whole struct
    typedef struct packed {
        logic        ssr_valid;
        logic [15:0] ssr_weight;
        logic [47:0] ssr_spec_rgb;
        logic [47:0] env_spec_rgb;
        logic [47:0] view_xyz;
        logic [47:0] normal_xyz;
        logic [15:0] roughness;
        logic [47:0] f0_rgb;
    } pixel_t;

    // Directed row: typed answer used only when known is set
    typedef struct {
        pixel_t      px;
        bit          known;
        logic [47:0] rgb;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    logic [47:0] spec_q[$];
    dir_row_t    dir_rows[$];
    int          n_sent = 0;
    int          n_blend = 0;
    int          n_checked = 0;
    int          n_sat = 0;
    int          n_mismatch = 0;
    int          rdy_left = 0;
    int          rdy_pick;
    logic [47:0] want_rgb;

    fresnel_specular_reflection_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Specular color of one pixel, truncating fixed point
    function automatic logic [47:0] shade_pixel(pixel_t px);
        longint          dot;
        longint unsigned cosv, base, pw, rgh, om, wgt, blend;
        longint unsigned f, m, fr, col, o;
        logic [47:0]     rgb;
        int              k;
        dot = 0;
        for (k = 0; k < 3; k++) begin
            dot += longint'($signed(px.normal_xyz[16*k +: 16]))
                 * longint'($signed(px.view_xyz[16*k +: 16]));
        end
        // clamp N.V to [0, 1]
        if (dot <= 0) begin
            cosv = 0;
        end else begin
            cosv = longint'(dot >>> 15);
            if (cosv > Q15_ONE) begin
                cosv = Q15_ONE;
            end
        end
        // (1 - c)^5
        base = Q15_ONE - cosv;
        pw = base;
        for (k = 0; k < 4; k++) begin
            pw = (pw * base) >> 15;
        end
        rgh = (px.roughness > Q15_ONE) ? Q15_ONE : px.roughness;
        om = Q15_ONE - rgh;
        wgt = (px.ssr_weight > Q15_ONE) ? Q15_ONE : px.ssr_weight;
        blend = (wgt * om) >> 15;
        for (k = 0; k < 3; k++) begin
            f = px.f0_rgb[16*k +: 16];
            m = (om > f) ? om : f;
            fr = f + (((m - f) * pw) >> 15);
            col = px.env_spec_rgb[16*k +: 16];
            if (px.ssr_valid) begin
                col = (col * (Q15_ONE - blend)
                       + longint'(px.ssr_spec_rgb[16*k +: 16]) * blend) >> 15;
            end
            o = (fr * col) >> 15;
            if (o > CH_MAX) begin
                o = CH_MAX;
            end
            rgb[16*k +: 16] = o[15:0];
        end
        return rgb;
    endfunction

    function automatic pixel_t mk_pix(logic [47:0] f0, logic [15:0] rough,
                                      logic [47:0] nrm, logic [47:0] vw,
                                      logic [47:0] env, logic [47:0] ssr,
                                      logic valid, logic [15:0] wgt);
        pixel_t px;
        px.f0_rgb       = f0;
        px.roughness    = rough;
        px.normal_xyz   = nrm;
        px.view_xyz     = vw;
        px.env_spec_rgb = env;
        px.ssr_spec_rgb = ssr;
        px.ssr_valid    = valid;
        px.ssr_weight   = wgt;
        return px;
    endfunction

    // Signed component in [-lim, lim] as a 16-bit pattern
    function automatic logic [15:0] rand_comp(int lim);
        return 16'($urandom_range(0, 2 * lim) - lim);
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly plausible pixels; some full-range bit patterns
    function automatic pixel_t rand_pixel();
        pixel_t px;
        int     k;
        int     vmode;
        px = rand48() ? '0 : '0;
        for (k = 0; k < 3; k++) begin
            px.f0_rgb[16*k +: 16]       = 16'($urandom_range(0, 32768));
            px.env_spec_rgb[16*k +: 16] = 16'($urandom_range(0, 8192));
            px.ssr_spec_rgb[16*k +: 16] = 16'($urandom_range(0, 8192));
        end
        if ($urandom_range(0, 9) < 3) px.f0_rgb = rand48();
        if ($urandom_range(0, 9) < 3) px.env_spec_rgb = rand48();
        if ($urandom_range(0, 9) < 3) px.ssr_spec_rgb = rand48();
        px.roughness = ($urandom_range(0, 19) < 3) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 32768));
        px.ssr_weight = ($urandom_range(0, 19) < 3) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 32768));
        px.ssr_valid = 1'($urandom);
        vmode = $urandom_range(0, 9);
        for (k = 0; k < 3; k++) begin
            if (vmode < 3) begin
                // arbitrary, mostly not unit length
                px.normal_xyz[16*k +: 16] = 16'($urandom);
                px.view_xyz[16*k +: 16]   = 16'($urandom);
            end else if (vmode < 7) begin
                // near-aligned, |N| at most about one
                px.normal_xyz[16*k +: 16] = rand_comp(18918);
                px.view_xyz[16*k +: 16]   = px.normal_xyz[16*k +: 16] + rand_comp(3000);
            end else if (vmode < 9) begin
                // short vectors, small N.V
                px.normal_xyz[16*k +: 16] = rand_comp(4000);
                px.view_xyz[16*k +: 16]   = rand_comp(4000);
            end else begin
                // back-facing
                px.normal_xyz[16*k +: 16] = rand_comp(18918);
                px.view_xyz[16*k +: 16]   = -px.normal_xyz[16*k +: 16];
            end
        end
        return px;
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one word, wait for the handshake, log its expected result
    task automatic send_pixel(pixel_t px, bit known, logic [47:0] rgb, bit no_idle);
        int idle;
        {s_tuser, s_tdata} <= px;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        spec_q.insert(spec_q.size(), known ? rgb : shade_pixel(px));
        n_sent++;
        if (px.ssr_valid) n_blend++;
        idle = no_idle ? 0 : pick_idle();
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
    endtask

    // Hold the input off until the pipeline has drained
    task automatic drain();
        s_tvalid <= 1'b0;
        while (spec_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver: long ready stretches, short stalls, a few long stalls
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_pick = $urandom_range(0, 99);
            if (rdy_pick < 50) begin
                m_tready <= 1'b1;
                rdy_left <= $urandom_range(1, 40);
            end else if (rdy_pick < 92) begin
                m_tready <= 1'b0;
                rdy_left <= $urandom_range(1, 3);
            end else begin
                m_tready <= 1'b0;
                rdy_left <= $urandom_range(10, 40);
            end
        end else begin
            rdy_left <= rdy_left - 1;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (spec_q.size() == 0) begin
                $display("%0t: unexpected specular word %012h", $time, m_tdata);
                n_mismatch++;
            end else begin
                want_rgb = spec_q.pop_front();
                n_checked++;
                if (m_tdata !== want_rgb) begin
                    $display("%0t: specular_rgb mismatch: expected %012h, actual %012h",
                             $time, want_rgb, m_tdata);
                    n_mismatch++;
                end
                for (int k = 0; k < 3; k++) begin
                    if (m_tdata[16*k +: 16] === 16'hFFFF) n_sat++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        bit burst;
        // black in, black out
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix('0, '0, '0, '0, '0, '0, 1'b0, '0), 1'b1, 48'h0});
        // roughness of one or above and no F0: F is zero
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix('0, 16'hFFFF, AXIS_Z, AXIS_Z, 48'h1234_5678_9ABC,
                                 48'hFFFF_FFFF_FFFF, 1'b1, 16'h8000), 1'b1, 48'h0});
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix('0, 16'h8000, AXIS_X, NEG_Z, 48'hFFFF_FFFF_FFFF,
                                 '0, 1'b0, '0), 1'b1, 48'h0});
        // F0 of one passes the environment color through
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h8000_8000_8000, '0, AXIS_Z, AXIS_Z,
                                 48'h1000_1000_1000, '0, 1'b0, '0),
                          1'b1, 48'h1000_1000_1000});
        // equal colors under the SSR blend
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h8000_8000_8000, '0, AXIS_X, AXIS_Y,
                                 48'h1000_1000_1000, 48'h1000_1000_1000, 1'b1, 16'h4000),
                          1'b1, 48'h1000_1000_1000});
        // output saturation
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'hFFFF_FFFF_FFFF, '0, AXIS_Z, AXIS_Z,
                                 48'hFFFF_FFFF_FFFF, '0, 1'b0, '0),
                          1'b1, 48'hFFFF_FFFF_FFFF});
        // head-on, back-facing and grazing views
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h051E_051E_051E, '0, AXIS_Z, AXIS_Z,
                                 48'h1000_2000_3000, '0, 1'b0, '0), 1'b0, '0});
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h051E_0A3D_1EB8, 16'h2000, AXIS_Z, NEG_Z,
                                 48'h1000_2000_3000, '0, 1'b0, '0), 1'b0, '0});
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h051E_051E_051E, 16'h1000, AXIS_X, AXIS_Y,
                                 48'h0800_0800_0800, '0, 1'b0, '0), 1'b0, '0});
        // non-unit vectors, dot saturates
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h1000_2000_3000, 16'h0800, 48'h7FFF_7FFF_7FFF,
                                 48'h7FFF_7FFF_7FFF, 48'h2000_2000_2000, '0, 1'b0, '0),
                          1'b0, '0});
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h1000_2000_3000, 16'h0800, 48'h8000_8000_8000,
                                 48'h8000_8000_8000, 48'h2000_2000_2000, '0, 1'b0, '0),
                          1'b0, '0});
        // weight above one, weight exactly one, weight zero
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h2000_4000_6000, '0, AXIS_X, AXIS_X,
                                 48'h0400_0400_0400, 48'h3000_2000_1000, 1'b1, 16'hFFFF),
                          1'b0, '0});
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h0800_0800_0800, '0, AXIS_Y, AXIS_Z, '0,
                                 48'hFFFF_FFFF_FFFF, 1'b1, 16'h8000), 1'b0, '0});
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h0800_0800_0800, 16'h4000, AXIS_Y, AXIS_Y,
                                 48'h1800_0C00_0600, 48'hFFFF_FFFF_FFFF, 1'b1, '0),
                          1'b0, '0});
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h0800_0800_0800, 16'h8001, AXIS_Z, AXIS_X,
                                 48'h1800_0C00_0600, 48'h0100_0200_0300, 1'b1, 16'h8001),
                          1'b0, '0});
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'h7FFF_7FFF_7FFF, 16'h7FFF, 48'h5A82_0000_5A82,
                                 AXIS_Z, 48'hF000_F000_F000, 48'h0FFF_0FFF_0FFF,
                                 1'b1, 16'h7FFF), 1'b0, '0});
        // every field at its maximum bit pattern
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix('1, '1, '1, '1, '1, '1, 1'b1, '1), 1'b0, '0});
        dir_rows.insert(dir_rows.size(),
                        '{mk_pix(48'hFFFF_0000_8000, 16'h0001, 48'h0001_FFFF_8001,
                                 48'h7FFF_0001_8000, 48'hFFFF_0001_1000,
                                 48'h0000_FFFF_0001, 1'b1, 16'h0001), 1'b0, '0});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_pixel(dir_rows[i].px, dir_rows[i].known, dir_rows[i].rgb, 1'b0);
        end
        drain();

        burst = 1'b0;
        for (int i = 0; i < RAND_PIXELS; i++) begin
            if (i % CHUNK == 0) burst = ($urandom_range(0, 3) == 0);
            if (i == RAND_PIXELS / 2) drain();
            send_pixel(rand_pixel(), 1'b0, '0, burst);
        end
        drain();
        repeat (2 * NUM_STAGES) @(posedge aclk);

        $display("Ran %0d pixel words (%0d directed), %0d with the SSR blend.",
                 n_sent, dir_rows.size(), n_blend);
        $display("Checked %0d specular words, %0d saturated channels, %0d errors.",
                 n_checked, n_sat, n_mismatch + spec_q.size());
        if (n_mismatch == 0 && spec_q.size() == 0) begin
            $display("fresnel_specular_reflection_top_tb: PASS");
        end else begin
            $display("fresnel_specular_reflection_top_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d words still expected.", spec_q.size());
        $display("fresnel_specular_reflection_top_tb: FAIL");
        $finish;
    end

endmodule
